// ===== hw/rtl/keypad_integer_calculator_core_macros.svh =====
// Assertion macros used by the keypad calculator controller.
`ifndef KEYPAD_INTEGER_CALCULATOR_CORE_MACROS_SVH
`define KEYPAD_INTEGER_CALCULATOR_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define KIC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define KIC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define KIC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/kic_pkg.sv =====
// Shared types, codes and the key decode table of the keypad calculator.
package kic_pkg;

	localparam int MAX_DIGITS = 14;
	localparam int DIV_STEPS  = 16;

	// Symbol classes
	localparam logic [2:0] CLS_NONE   = 3'd0;
	localparam logic [2:0] CLS_DIGIT  = 3'd1;
	localparam logic [2:0] CLS_OPER   = 3'd2;
	localparam logic [2:0] CLS_EQUALS = 3'd3;
	localparam logic [2:0] CLS_CLEAR  = 3'd4;

	// Operations
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	// Display kinds
	localparam logic [1:0] KIND_BLANK  = 2'd0;
	localparam logic [1:0] KIND_ENTRY  = 2'd1;
	localparam logic [1:0] KIND_RESULT = 2'd2;

	typedef struct packed {
		logic [2:0] cls;
		logic [3:0] arg;
	} kic_sym_t;

	typedef struct packed {
		logic capture;
		logic div_start;
		logic div_step;
		logic apply;
		logic emit;
	} kic_cmd_t;

	typedef struct packed {
		logic needs_div;
		logic div_done;
	} kic_stat_t;

	// Keypad layout by row: 7 8 9 /, 4 5 6 *, 1 2 3 -, C 0 = +
	function automatic kic_sym_t key_decode(input logic [4:0] code);
		kic_sym_t s;
		s.cls = CLS_NONE;
		s.arg = 4'd0;
		case (code)
			5'd1:  begin s.cls = CLS_DIGIT;  s.arg = 4'd7; end
			5'd2:  begin s.cls = CLS_DIGIT;  s.arg = 4'd4; end
			5'd3:  begin s.cls = CLS_DIGIT;  s.arg = 4'd1; end
			5'd4:  begin s.cls = CLS_CLEAR; end
			5'd5:  begin s.cls = CLS_DIGIT;  s.arg = 4'd8; end
			5'd6:  begin s.cls = CLS_DIGIT;  s.arg = 4'd5; end
			5'd7:  begin s.cls = CLS_DIGIT;  s.arg = 4'd2; end
			5'd8:  begin s.cls = CLS_DIGIT;  s.arg = 4'd0; end
			5'd9:  begin s.cls = CLS_DIGIT;  s.arg = 4'd9; end
			5'd10: begin s.cls = CLS_DIGIT;  s.arg = 4'd6; end
			5'd11: begin s.cls = CLS_DIGIT;  s.arg = 4'd3; end
			5'd12: begin s.cls = CLS_EQUALS; end
			5'd13: begin s.cls = CLS_OPER;   s.arg = {2'b00, OP_DIV}; end
			5'd14: begin s.cls = CLS_OPER;   s.arg = {2'b00, OP_MUL}; end
			5'd15: begin s.cls = CLS_OPER;   s.arg = {2'b00, OP_SUB}; end
			5'd16: begin s.cls = CLS_OPER;   s.arg = {2'b00, OP_ADD}; end
			default: begin s.cls = CLS_NONE; end
		endcase
		return s;
	endfunction

endpackage

// ===== hw/rtl/kic_if.sv =====
// Valid/ready channel interfaces for key items and display items.
interface kic_key_if;
	logic       valid;
	logic       ready;
	logic [4:0] key_code;

	modport source(output valid, output key_code, input ready);
	modport sink(input valid, input key_code, output ready);
endinterface

interface kic_disp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] shown_value;
	logic [1:0]         shown_kind;
	logic [3:0]         digits_shown;
	logic               second_phase;
	logic               divide_by_zero;

	modport source(output valid, output shown_value, output shown_kind, output digits_shown,
		output second_phase, output divide_by_zero, input ready);
	modport sink(input valid, input shown_value, input shown_kind, input digits_shown,
		input second_phase, input divide_by_zero, output ready);
endinterface

// ===== hw/rtl/kic_dp.sv =====
// Calculator datapath: operand entry, arithmetic, iterative divider, display register.
module kic_dp #(
	parameter int MAX_DIGITS = kic_pkg::MAX_DIGITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  kic_pkg::kic_cmd_t  cmd,
	output kic_pkg::kic_stat_t stat,
	input  logic [4:0]         key_code,
	output logic [15:0]        shown_value,
	output logic [1:0]         shown_kind,
	output logic [3:0]         digits_shown,
	output logic               second_phase,
	output logic               divide_by_zero
);

	localparam int CW = $clog2(kic_pkg::DIV_STEPS + 1);

	logic [4:0]  key_q;
	logic [15:0] a_q, b_q, last_q;
	logic [1:0]  op_q, kind_q;
	logic        phase_q, zflag_q;
	logic [3:0]  cnt_q;

	logic [16:0]   rem_q;
	logic [15:0]   quo_q, dmag_q;
	logic          neg_q;
	logic [CW-1:0] divcnt_q;

	kic_pkg::kic_sym_t sym;
	logic [15:0] cur_op, digit_next, mag_a, mag_b, quot, prod, arith;
	logic [31:0] prod_full;
	logic [16:0] rem_sh;
	logic        digit_ok;

	assign sym        = kic_pkg::key_decode(key_q);
	assign cur_op     = phase_q ? b_q : a_q;
	assign digit_next = (cur_op << 3) + (cur_op << 1) + {12'd0, sym.arg};
	assign digit_ok   = cnt_q < 4'(MAX_DIGITS);

	assign mag_a = a_q[15] ? (~a_q + 16'd1) : a_q;
	assign mag_b = b_q[15] ? (~b_q + 16'd1) : b_q;
	assign quot  = neg_q ? (~quo_q + 16'd1) : quo_q;
	assign rem_sh = {rem_q[15:0], quo_q[15]};

	assign prod_full = a_q * b_q;
	assign prod      = prod_full[15:0];

	always_comb begin
		case (op_q)
			kic_pkg::OP_ADD: arith = a_q + b_q;
			kic_pkg::OP_SUB: arith = a_q - b_q;
			kic_pkg::OP_MUL: arith = prod;
			kic_pkg::OP_DIV: arith = (b_q == 16'd0) ? 16'd0 : quot;
			default:         arith = 16'd0;
		endcase
	end

	assign stat.needs_div = (sym.cls == kic_pkg::CLS_EQUALS) && phase_q &&
		(op_q == kic_pkg::OP_DIV) && (b_q != 16'd0);
	assign stat.div_done  = (divcnt_q == '0);

	// Key latch and divider working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			key_q <= key_code;
		end
		if (cmd.div_start) begin
			rem_q    <= '0;
			quo_q    <= mag_a;
			dmag_q   <= mag_b;
			neg_q    <= a_q[15] ^ b_q[15];
			divcnt_q <= CW'(kic_pkg::DIV_STEPS);
		end else if (cmd.div_step) begin
			if (rem_sh >= {1'b0, dmag_q}) begin
				rem_q <= rem_sh - {1'b0, dmag_q};
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[14:0], 1'b0};
			end
			divcnt_q <= divcnt_q - CW'(1);
		end
	end

	// Calculator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q     <= '0;
			b_q     <= '0;
			op_q    <= kic_pkg::OP_ADD;
			phase_q <= 1'b0;
			cnt_q   <= '0;
			kind_q  <= kic_pkg::KIND_BLANK;
			last_q  <= '0;
			zflag_q <= 1'b0;
		end else if (cmd.apply) begin
			case (sym.cls)
				kic_pkg::CLS_DIGIT: begin
					if (digit_ok) begin
						if (phase_q) b_q <= digit_next;
						else a_q <= digit_next;
						cnt_q  <= cnt_q + 4'd1;
						kind_q <= kic_pkg::KIND_ENTRY;
					end
				end
				kic_pkg::CLS_OPER: begin
					op_q    <= sym.arg[1:0];
					phase_q <= 1'b1;
					b_q     <= '0;
					cnt_q   <= '0;
					kind_q  <= kic_pkg::KIND_BLANK;
				end
				kic_pkg::CLS_EQUALS: begin
					if (phase_q) begin
						last_q  <= arith;
						zflag_q <= (op_q == kic_pkg::OP_DIV) && (b_q == 16'd0);
						kind_q  <= kic_pkg::KIND_RESULT;
					end
				end
				kic_pkg::CLS_CLEAR: begin
					a_q     <= '0;
					b_q     <= '0;
					op_q    <= kic_pkg::OP_ADD;
					phase_q <= 1'b0;
					cnt_q   <= '0;
					kind_q  <= kic_pkg::KIND_BLANK;
					last_q  <= '0;
					zflag_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Display output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (kind_q)
				kic_pkg::KIND_ENTRY: begin
					shown_value  <= cur_op;
					digits_shown <= cnt_q;
				end
				kic_pkg::KIND_RESULT: begin
					shown_value  <= last_q;
					digits_shown <= '0;
				end
				default: begin
					shown_value  <= '0;
					digits_shown <= '0;
				end
			endcase
			shown_kind     <= kind_q;
			second_phase   <= phase_q;
			divide_by_zero <= zflag_q;
		end
	end

endmodule

// ===== hw/rtl/kic_ctrl.sv =====
// Calculator controller: sequences capture, execute, divide and emit of one key item.
`include "keypad_integer_calculator_core_macros.svh"

module kic_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  kic_pkg::kic_stat_t stat,
	output kic_pkg::kic_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q, state_d;
	logic       out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (stat.needs_div) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					cmd.apply = 1'b1;
					state_d   = ST_EMIT;
				end
			end
			ST_DIV: begin
				if (stat.div_done) begin
					cmd.apply = 1'b1;
					state_d   = ST_EMIT;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_EMIT: begin
				// hold until the display register is free or being drained
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`KIC_ASSERT_ALWAYS(a_cmd_onehot, $onehot0({cmd.capture, cmd.div_start, cmd.div_step, cmd.apply, cmd.emit}), "controller issued more than one command")
	`KIC_ASSERT_NEXT(a_capture_exec, cmd.capture, state_q == ST_EXEC, "captured key not executed next")
	`KIC_ASSERT_NEXT(a_div_holds, (state_q == ST_DIV) && !stat.div_done, state_q == ST_DIV, "divide left early")
	`KIC_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid_q, "emitted item not presented")
	`KIC_ASSERT_SAME(a_emit_no_overwrite, cmd.emit && out_valid_q, out_ready, "pending item overwritten")

endmodule

// ===== hw/rtl/keypad_integer_calculator_core.sv =====
// Top level of the four-function keypad integer calculator.
//
// Usage:
//   keys : one item per scanned key press, key_code = column*4 + row + 1.
//          Codes outside 1..16 leave the state alone but still report the display.
//   disp : exactly one item per key item, describing the display after the key:
//          value shown, its kind (blank, entry, result), digit count, phase and
//          the divide-by-zero flag.
// Sequence: a key item is captured, then applied in the execute state and written to
// the display register in the emit state, which waits while an earlier item is still
// pending; an equals that divides by a non-zero operand first runs the 16-step
// shift/subtract divider. Keys are taken one item at a time: keys.ready is high only
// while the controller is idle, so a new item is taken after the last has been emitted.
// The display register parts the two sides: a stalled receiver does not block the
// next key from being taken, but the controller holds the next result until the
// register is drained.
// Reset: arst_n clears both operands, the pending operation (add), the phase, digit count,
// last result and flag, sets the entry kind to blank and drops disp.valid; the display register itself is not reset.
module keypad_integer_calculator_core #(
	parameter int MAX_DIGITS = kic_pkg::MAX_DIGITS
) (
	input logic        clk,
	input logic        arst_n,
	kic_key_if.sink    keys,
	kic_disp_if.source disp
);

	kic_pkg::kic_cmd_t  cmd;
	kic_pkg::kic_stat_t stat;
	logic               in_ready;
	logic               out_valid;
	logic [15:0]        shown_value;

	// Sequence each key item: capture, execute or divide, then emit
	kic_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (keys.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (disp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Hold the calculator state and the display register
	kic_dp #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.key_code       (keys.key_code),
		.shown_value    (shown_value),
		.shown_kind     (disp.shown_kind),
		.digits_shown   (disp.digits_shown),
		.second_phase   (disp.second_phase),
		.divide_by_zero (disp.divide_by_zero)
	);

	assign keys.ready       = in_ready;
	assign disp.valid       = out_valid;
	assign disp.shown_value = $signed(shown_value);

endmodule
